/* hw/rtl/srt_pkg.sv */
`default_nettype none

package srt_pkg;

  // sizing
  localparam int MAX_SCOPES    = 16;
  localparam int MAX_RESOURCES = 16;
  localparam int ACCESS_KINDS  = 4;

  localparam int SAW      = (MAX_SCOPES > 1) ? $clog2(MAX_SCOPES) : 1;
  localparam int RAW      = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
  localparam int SC_W     = $clog2(MAX_SCOPES + 1);
  localparam int RC_W     = $clog2(MAX_RESOURCES + 1);
  localparam int MAX_IDX  = (MAX_SCOPES > MAX_RESOURCES) ? MAX_SCOPES : MAX_RESOURCES;
  localparam int CNT_W    = $clog2(MAX_IDX + 1);
  localparam int CMP_W    = ((SC_W > RC_W) ? SC_W : RC_W) + 4;
  localparam int UNIT_W   = (MAX_SCOPES > ACCESS_KINDS) ? MAX_SCOPES : ACCESS_KINDS;
  localparam int SEL_W    = (UNIT_W > 1) ? $clog2(UNIT_W) : 1;
  localparam int ACC_AW   = SAW + RAW;
  localparam int ACC_DEPTH   = 1 << ACC_AW;
  localparam int REACH_DEPTH = 1 << SAW;

  localparam logic [3:0] KIND_LIMIT = 4'(ACCESS_KINDS);

  typedef logic [SAW-1:0]          scope_idx_t;
  typedef logic [RAW-1:0]          res_idx_t;
  typedef logic [ACC_AW-1:0]       acc_addr_t;
  typedef logic [SC_W-1:0]         scount_t;
  typedef logic [RC_W-1:0]         rcount_t;
  typedef logic [CNT_W-1:0]        cnt_t;
  typedef logic [CMP_W-1:0]        cmp_t;
  typedef logic [MAX_SCOPES-1:0]   row_t;
  typedef logic [ACCESS_KINDS-1:0] acc_word_t;
  typedef logic [UNIT_W-1:0]       unit_word_t;
  typedef logic [SEL_W-1:0]        unit_sel_t;
  typedef logic [3:0]              nibble_t;

  // operation codes
  typedef enum logic [2:0] {
    FUNC_ADD_SCOPE    = 3'd0,
    FUNC_ADD_RESOURCE = 3'd1,
    FUNC_ADD_EDGE     = 3'd2,
    FUNC_GRANT        = 3'd3,
    FUNC_QUERY_CONT   = 3'd4,
    FUNC_QUERY_ACCESS = 3'd5
  } func_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SWEEP,
    S_ECHK,
    S_MERGE,
    S_QCONT,
    S_QACC,
    S_GRANT,
    S_RESULT
  } state_e;

  typedef struct packed {
    logic [2:0] func;
    logic [3:0] scope_a;
    logic [3:0] scope_b;
    logic [3:0] resource_index;
    logic [2:0] access_kind;
  } in_item_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] alloc_idx;
  } out_item_t;

  // control of the shared row unit
  typedef struct packed {
    unit_sel_t sel;
    logic      set_bit;
  } unit_ctl_t;

endpackage

`default_nettype wire

/* hw/rtl/srt_ram.sv */
`default_nettype none

module srt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

/* hw/rtl/srt_row_unit.sv */
`default_nettype none

module srt_row_unit (
  input  wire srt_pkg::unit_word_t word,
  input  wire srt_pkg::unit_word_t merge,
  input  wire srt_pkg::unit_ctl_t  ctl,
  output logic                     hit,
  output srt_pkg::unit_word_t      merged
);

  srt_pkg::unit_word_t onehot;

  // bit test at the selected position
  assign hit = word[ctl.sel];

  // or-merge, optionally setting the selected bit
  assign onehot = ctl.set_bit ? (srt_pkg::unit_word_t'(1) << ctl.sel) : '0;
  assign merged = word | merge | onehot;

endmodule

`default_nettype wire

/* hw/rtl/scope_reachability_table.sv */
`default_nettype none

// channel  | ports                        | payload
// ---------+------------------------------+----------------------
// input    | in_valid, in_ready, in_data  | srt_pkg::in_item_t
// result   | out_valid, out_ready, out_data | srt_pkg::out_item_t
//
// one transaction at a time; in_ready is high only while the sequencer idles
// add edge: walks every allocated scope row, one matrix row per cycle
// add scope / add resource: clear MAX_RESOURCES or MAX_SCOPES permission words
// queries and grant: the tables are read through a registered read port
// refusals and self edge go from decode to the result; an edge refused as a cycle passes the cycle check first
// a result waits in the output register; a new transaction is taken meanwhile
// reset clears counts and control; table contents need no clear after reset

module scope_reachability_table (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire srt_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output srt_pkg::out_item_t      out_data
);

  srt_pkg::state_e    state_r, state_nxt;
  srt_pkg::in_item_t  item_r;
  srt_pkg::scount_t   sc_r, sc_nxt;
  srt_pkg::rcount_t   rc_r, rc_nxt;
  srt_pkg::cnt_t      cnt_r, cnt_nxt;
  srt_pkg::cnt_t      n_r, n_nxt;
  srt_pkg::row_t      child_r, child_nxt;
  logic               res_ok_r, res_ok_nxt;
  srt_pkg::nibble_t   res_idx_r, res_idx_nxt;
  logic               out_valid_r, out_valid_nxt;
  srt_pkg::out_item_t out_item_r, out_item_nxt;

  logic                 reach_we;
  srt_pkg::scope_idx_t  reach_waddr, reach_raddr;
  srt_pkg::row_t        reach_wdata, reach_rdata;
  logic                 acc_we;
  srt_pkg::acc_addr_t   acc_waddr, acc_raddr;
  srt_pkg::acc_word_t   acc_wdata, acc_rdata;

  srt_pkg::unit_word_t  u_word, u_merge, u_merged;
  srt_pkg::unit_ctl_t   u_ctl;
  logic                 u_hit;

  logic                 a_ok, b_ok, r_ok, k_ok;
  srt_pkg::acc_addr_t   item_acc_addr;
  srt_pkg::cnt_t        prev_idx;
  logic                 sweep_last;

  // tables
  srt_ram #(
    .WIDTH (srt_pkg::MAX_SCOPES),
    .DEPTH (srt_pkg::REACH_DEPTH)
  ) u_reach_ram (
    .clk   (clk),
    .we    (reach_we),
    .waddr (reach_waddr),
    .wdata (reach_wdata),
    .raddr (reach_raddr),
    .rdata (reach_rdata)
  );

  srt_ram #(
    .WIDTH (srt_pkg::ACCESS_KINDS),
    .DEPTH (srt_pkg::ACC_DEPTH)
  ) u_acc_ram (
    .clk   (clk),
    .we    (acc_we),
    .waddr (acc_waddr),
    .wdata (acc_wdata),
    .raddr (acc_raddr),
    .rdata (acc_rdata)
  );

  srt_row_unit u_row_unit (
    .word   (u_word),
    .merge  (u_merge),
    .ctl    (u_ctl),
    .hit    (u_hit),
    .merged (u_merged)
  );

  // operand checks against allocated counts
  assign a_ok = srt_pkg::cmp_t'(item_r.scope_a) < srt_pkg::cmp_t'(sc_r);
  assign b_ok = srt_pkg::cmp_t'(item_r.scope_b) < srt_pkg::cmp_t'(sc_r);
  assign r_ok = srt_pkg::cmp_t'(item_r.resource_index) < srt_pkg::cmp_t'(rc_r);
  assign k_ok = {1'b0, item_r.access_kind} < srt_pkg::KIND_LIMIT;

  assign item_acc_addr = {srt_pkg::scope_idx_t'(item_r.scope_a),
                          srt_pkg::res_idx_t'(item_r.resource_index)};
  assign prev_idx      = cnt_r - srt_pkg::cnt_t'(1);

  assign sweep_last = (srt_pkg::func_e'(item_r.func) == srt_pkg::FUNC_ADD_SCOPE) ?
                      (cnt_r == srt_pkg::cnt_t'(srt_pkg::MAX_RESOURCES - 1)) :
                      (cnt_r == srt_pkg::cnt_t'(srt_pkg::MAX_SCOPES - 1));

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= srt_pkg::S_IDLE;
      sc_r        <= '0;
      rc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sc_r        <= sc_nxt;
      rc_r        <= rc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
    cnt_r      <= cnt_nxt;
    n_r        <= n_nxt;
    child_r    <= child_nxt;
    res_ok_r   <= res_ok_nxt;
    res_idx_r  <= res_idx_nxt;
    out_item_r <= out_item_nxt;
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    sc_nxt        = sc_r;
    rc_nxt        = rc_r;
    cnt_nxt       = cnt_r;
    n_nxt         = n_r;
    child_nxt     = child_r;
    res_ok_nxt    = res_ok_r;
    res_idx_nxt   = res_idx_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_item_nxt  = out_item_r;

    reach_we    = 1'b0;
    reach_waddr = '0;
    reach_wdata = srt_pkg::row_t'(u_merged);
    reach_raddr = '0;
    acc_we      = 1'b0;
    acc_waddr   = item_acc_addr;
    acc_wdata   = srt_pkg::acc_word_t'(u_merged);
    acc_raddr   = item_acc_addr;

    u_word      = '0;
    u_merge     = '0;
    u_ctl.sel   = '0;
    u_ctl.set_bit = 1'b0;

    unique case (state_r)
      srt_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = srt_pkg::S_DECODE;
        end
      end

      srt_pkg::S_DECODE: begin
        res_ok_nxt  = 1'b0;
        res_idx_nxt = '0;
        state_nxt   = srt_pkg::S_RESULT;
        case (srt_pkg::func_e'(item_r.func))
          srt_pkg::FUNC_ADD_SCOPE: begin
            if (sc_r < srt_pkg::scount_t'(srt_pkg::MAX_SCOPES)) begin
              // new row holds only its diagonal bit
              u_ctl.sel     = srt_pkg::unit_sel_t'(sc_r);
              u_ctl.set_bit = 1'b1;
              reach_we      = 1'b1;
              reach_waddr   = srt_pkg::scope_idx_t'(sc_r);
              res_ok_nxt    = 1'b1;
              res_idx_nxt   = srt_pkg::nibble_t'(sc_r);
              n_nxt         = srt_pkg::cnt_t'(sc_r);
              cnt_nxt       = '0;
              sc_nxt        = sc_r + srt_pkg::scount_t'(1);
              state_nxt     = srt_pkg::S_SWEEP;
            end
          end
          srt_pkg::FUNC_ADD_RESOURCE: begin
            if (rc_r < srt_pkg::rcount_t'(srt_pkg::MAX_RESOURCES)) begin
              res_ok_nxt  = 1'b1;
              res_idx_nxt = srt_pkg::nibble_t'(rc_r);
              n_nxt       = srt_pkg::cnt_t'(rc_r);
              cnt_nxt     = '0;
              rc_nxt      = rc_r + srt_pkg::rcount_t'(1);
              state_nxt   = srt_pkg::S_SWEEP;
            end
          end
          srt_pkg::FUNC_ADD_EDGE: begin
            if (a_ok && b_ok) begin
              if (item_r.scope_a == item_r.scope_b) begin
                res_ok_nxt = 1'b1;
              end else begin
                reach_raddr = srt_pkg::scope_idx_t'(item_r.scope_b);
                state_nxt   = srt_pkg::S_ECHK;
              end
            end
          end
          srt_pkg::FUNC_GRANT: begin
            if (a_ok && r_ok && k_ok) begin
              state_nxt = srt_pkg::S_GRANT;
            end
          end
          srt_pkg::FUNC_QUERY_CONT: begin
            if (a_ok && b_ok) begin
              reach_raddr = srt_pkg::scope_idx_t'(item_r.scope_a);
              state_nxt   = srt_pkg::S_QCONT;
            end
          end
          srt_pkg::FUNC_QUERY_ACCESS: begin
            if (a_ok && r_ok && k_ok) begin
              state_nxt = srt_pkg::S_QACC;
            end
          end
          default: begin
          end
        endcase
      end

      // clear the permission row or column of the new index
      srt_pkg::S_SWEEP: begin
        acc_we    = 1'b1;
        acc_wdata = '0;
        if (srt_pkg::func_e'(item_r.func) == srt_pkg::FUNC_ADD_SCOPE) begin
          acc_waddr = {n_r[srt_pkg::SAW-1:0], cnt_r[srt_pkg::RAW-1:0]};
        end else begin
          acc_waddr = {cnt_r[srt_pkg::SAW-1:0], n_r[srt_pkg::RAW-1:0]};
        end
        cnt_nxt = cnt_r + srt_pkg::cnt_t'(1);
        if (sweep_last) begin
          state_nxt = srt_pkg::S_RESULT;
        end
      end

      // cycle check: refuse when the child already contains the parent
      srt_pkg::S_ECHK: begin
        u_word    = srt_pkg::unit_word_t'(reach_rdata);
        u_ctl.sel = srt_pkg::unit_sel_t'(item_r.scope_a);
        child_nxt = reach_rdata;
        if (u_hit) begin
          state_nxt = srt_pkg::S_RESULT;
        end else begin
          reach_raddr = '0;
          cnt_nxt     = srt_pkg::cnt_t'(1);
          state_nxt   = srt_pkg::S_MERGE;
        end
      end

      // row prev_idx is in; fold child in if it reaches the parent
      srt_pkg::S_MERGE: begin
        u_word      = srt_pkg::unit_word_t'(reach_rdata);
        u_merge     = srt_pkg::unit_word_t'(child_r);
        u_ctl.sel   = srt_pkg::unit_sel_t'(item_r.scope_a);
        reach_we    = u_hit;
        reach_waddr = srt_pkg::scope_idx_t'(prev_idx);
        reach_raddr = srt_pkg::scope_idx_t'(cnt_r);
        if (cnt_r == srt_pkg::cnt_t'(sc_r)) begin
          res_ok_nxt = 1'b1;
          state_nxt  = srt_pkg::S_RESULT;
        end else begin
          cnt_nxt = cnt_r + srt_pkg::cnt_t'(1);
        end
      end

      srt_pkg::S_QCONT: begin
        u_word     = srt_pkg::unit_word_t'(reach_rdata);
        u_ctl.sel  = srt_pkg::unit_sel_t'(item_r.scope_b);
        res_ok_nxt = u_hit;
        state_nxt  = srt_pkg::S_RESULT;
      end

      srt_pkg::S_QACC: begin
        u_word     = srt_pkg::unit_word_t'(acc_rdata);
        u_ctl.sel  = srt_pkg::unit_sel_t'(item_r.access_kind);
        res_ok_nxt = u_hit;
        state_nxt  = srt_pkg::S_RESULT;
      end

      // read-modify-write of one permission word
      srt_pkg::S_GRANT: begin
        u_word        = srt_pkg::unit_word_t'(acc_rdata);
        u_ctl.sel     = srt_pkg::unit_sel_t'(item_r.access_kind);
        u_ctl.set_bit = 1'b1;
        acc_we        = 1'b1;
        res_ok_nxt    = 1'b1;
        state_nxt     = srt_pkg::S_RESULT;
      end

      // hand the result to the output register once it is free
      srt_pkg::S_RESULT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt          = 1'b1;
          out_item_nxt.ok        = res_ok_r;
          out_item_nxt.alloc_idx = res_idx_r;
          state_nxt              = srt_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = srt_pkg::S_IDLE;
      end
    endcase
  end

  assign in_ready  = (state_r == srt_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

endmodule

`default_nettype wire

/* hw/rtl/srt_checker.sv */
`default_nettype none

module srt_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire srt_pkg::out_item_t out_data
);

  // stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // one transaction at a time: the input closes after an accept
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input stayed open after accept");

  // a failed operation reports index zero
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.ok |-> out_data.alloc_idx == 4'd0)
    else $error("nonzero index on failed operation");

  // out of reset: idle and no result
  assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> in_ready && !out_valid)
    else $error("not idle after reset");

  // a result never appears while the input is still open
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result without a transaction in flight");

endmodule

bind scope_reachability_table srt_checker u_srt_checker (.*);

`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
  import srt_pkg::*;

  // unused operation codes, both answered with a refusal
  localparam logic [2:0] FUNC_SPARE_6 = 3'd6;
  localparam logic [2:0] FUNC_SPARE_7 = 3'd7;

  localparam int RANDOM_ITEMS = 400;
  localparam int PHASE1_AT    = 130;
  localparam int PHASE2_AT    = 260;
  localparam int LONG_HOLD    = 150;
  localparam int DRAIN_CYCLES = 40;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  scope_reachability_table uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // shadow copy of the containment matrix and permission table
  row_t        reach_q [MAX_SCOPES];
  acc_word_t   perm_q  [MAX_SCOPES][MAX_RESOURCES];
  int unsigned n_scopes;
  int unsigned n_res;

  out_item_t   pending_results[$];
  in_item_t    recent_grant;

  typedef struct {
    in_item_t  op;
    bit        typed;
    out_item_t want;
  } stim_row_t;

  stim_row_t   directed_rows[$];

  int err_cnt;
  int n_sent;
  int n_checked;
  int n_merged;
  int n_cycles;
  int tx_idle;
  int rx_idle;
  bit hold_req;

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // containment and permission update for one transaction
  function automatic out_item_t predict_table_op(in_item_t op);
    out_item_t res;
    bit        a_ok;
    bit        b_ok;
    bit        r_ok;
    bit        k_ok;
    row_t      child;
    int        i;
    res  = '0;
    a_ok = op.scope_a < n_scopes;
    b_ok = op.scope_b < n_scopes;
    r_ok = op.resource_index < n_res;
    k_ok = op.access_kind < ACCESS_KINDS;
    case (op.func)
      FUNC_ADD_SCOPE: begin
        if (n_scopes < MAX_SCOPES) begin
          for (i = 0; i < n_scopes; i++) reach_q[i][n_scopes] = 1'b0;
          reach_q[n_scopes] = '0;
          reach_q[n_scopes][n_scopes] = 1'b1;
          for (i = 0; i < MAX_RESOURCES; i++) perm_q[n_scopes][i] = '0;
          res.ok = 1'b1;
          res.alloc_idx = 4'(n_scopes);
          n_scopes++;
        end
      end
      FUNC_ADD_RESOURCE: begin
        if (n_res < MAX_RESOURCES) begin
          for (i = 0; i < MAX_SCOPES; i++) perm_q[i][n_res] = '0;
          res.ok = 1'b1;
          res.alloc_idx = 4'(n_res);
          n_res++;
        end
      end
      FUNC_ADD_EDGE: begin
        if (a_ok && b_ok) begin
          if (op.scope_a == op.scope_b) begin
            res.ok = 1'b1;
          end else if (!reach_q[op.scope_b][op.scope_a]) begin
            // every row reaching the parent takes in the child's row
            child = reach_q[op.scope_b];
            for (i = 0; i < n_scopes; i++)
              if (reach_q[i][op.scope_a]) reach_q[i] = reach_q[i] | child;
            res.ok = 1'b1;
            n_merged++;
          end else begin
            n_cycles++;
          end
        end
      end
      FUNC_GRANT: begin
        if (a_ok && r_ok && k_ok) begin
          perm_q[op.scope_a][op.resource_index][op.access_kind] = 1'b1;
          res.ok = 1'b1;
        end
      end
      FUNC_QUERY_CONT: begin
        if (a_ok && b_ok) res.ok = reach_q[op.scope_a][op.scope_b];
      end
      FUNC_QUERY_ACCESS: begin
        if (a_ok && r_ok && k_ok)
          res.ok = perm_q[op.scope_a][op.resource_index][op.access_kind];
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  function automatic void add_row(logic [2:0] f, logic [3:0] a, logic [3:0] b,
                                  logic [3:0] r, logic [2:0] k, bit typed,
                                  logic ok, logic [3:0] idx);
    stim_row_t row;
    row.op.func           = f;
    row.op.scope_a        = a;
    row.op.scope_b        = b;
    row.op.resource_index = r;
    row.op.access_kind    = k;
    row.typed             = typed;
    row.want.ok           = ok;
    row.want.alloc_idx    = idx;
    directed_rows.push_back(row);
  endfunction

  // mostly allocated indices, sometimes anything the field holds
  function automatic logic [3:0] pick_index(int unsigned count);
    if (count != 0 && $urandom_range(0, 99) < 85)
      return 4'($urandom_range(0, count - 1));
    return 4'($urandom_range(0, 15));
  endfunction

  function automatic in_item_t random_op();
    in_item_t   op;
    int         pick;
    logic [3:0] swap;
    pick              = $urandom_range(0, 99);
    op.scope_a        = pick_index(n_scopes);
    op.scope_b        = pick_index(n_scopes);
    op.resource_index = pick_index(n_res);
    op.access_kind    = ($urandom_range(0, 99) < 85) ?
                        3'($urandom_range(0, ACCESS_KINDS - 1)) :
                        3'($urandom_range(0, 7));
    if (pick < 9)       op.func = FUNC_ADD_SCOPE;
    else if (pick < 18) op.func = FUNC_ADD_RESOURCE;
    else if (pick < 48) op.func = FUNC_ADD_EDGE;
    else if (pick < 63) op.func = FUNC_GRANT;
    else if (pick < 80) op.func = FUNC_QUERY_CONT;
    else if (pick < 97) op.func = FUNC_QUERY_ACCESS;
    else                op.func = $urandom_range(0, 1) ? FUNC_SPARE_6 : FUNC_SPARE_7;
    // edges mostly point from lower to higher index so long chains build up
    if (op.func == FUNC_ADD_EDGE && op.scope_a > op.scope_b &&
        $urandom_range(0, 99) < 70) begin
      swap       = op.scope_a;
      op.scope_a = op.scope_b;
      op.scope_b = swap;
    end
    if (op.func == FUNC_GRANT) recent_grant = op;
    // half of the access queries ask about a recent grant
    if (op.func == FUNC_QUERY_ACCESS && $urandom_range(0, 1)) begin
      op.scope_a        = recent_grant.scope_a;
      op.resource_index = recent_grant.resource_index;
      op.access_kind    = recent_grant.access_kind;
    end
    return op;
  endfunction

  // offer one transaction, predict it once accepted
  task automatic offer(input in_item_t op, input bit typed, input out_item_t want);
    out_item_t predicted;
    while ($urandom_range(0, 99) < tx_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= op;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = predict_table_op(op);
    pending_results.push_back(typed ? want : predicted);
    n_sent++;
  endtask

  // stimulus
  initial begin
    in_item_t op;
    int       n;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    hold_req     = 1'b0;
    tx_idle      = 30;
    rx_idle      = 55;
    err_cnt      = 0;
    n_sent       = 0;
    n_checked    = 0;
    n_merged     = 0;
    n_cycles     = 0;
    n_scopes     = 0;
    n_res        = 0;
    recent_grant = '0;
    for (n = 0; n < MAX_SCOPES; n++) reach_q[n] = '0;

    // directed rows: func, a, b, resource, kind, typed, ok, allocated index
    add_row(FUNC_QUERY_CONT,    0,  0,  0, 0, 1, 0, 0);  // empty table
    add_row(FUNC_GRANT,         0,  0,  0, 0, 1, 0, 0);
    add_row(FUNC_ADD_EDGE,      0,  0,  0, 0, 1, 0, 0);
    add_row(FUNC_ADD_RESOURCE,  0,  0,  0, 0, 1, 1, 0);
    add_row(FUNC_ADD_SCOPE,     0,  0,  0, 0, 1, 1, 0);
    add_row(FUNC_ADD_SCOPE,     0,  0,  0, 0, 1, 1, 1);
    add_row(FUNC_ADD_SCOPE,     0,  0,  0, 0, 1, 1, 2);
    add_row(FUNC_QUERY_CONT,    1,  1,  0, 0, 1, 1, 0);  // diagonal
    add_row(FUNC_QUERY_CONT,    0,  1,  0, 0, 1, 0, 0);
    add_row(FUNC_ADD_EDGE,      0,  1,  0, 0, 0, 0, 0);
    add_row(FUNC_ADD_EDGE,      1,  2,  0, 0, 0, 0, 0);
    add_row(FUNC_QUERY_CONT,    0,  2,  0, 0, 0, 0, 0);  // transitive
    add_row(FUNC_QUERY_CONT,    2,  0,  0, 0, 0, 0, 0);
    add_row(FUNC_ADD_EDGE,      2,  0,  0, 0, 1, 0, 0);  // would close a cycle
    add_row(FUNC_ADD_EDGE,      1,  1,  0, 0, 1, 1, 0);  // self edge
    add_row(FUNC_ADD_EDGE,      0, 15,  0, 0, 1, 0, 0);  // child not allocated
    add_row(FUNC_GRANT,         2,  0,  0, 3, 0, 0, 0);
    add_row(FUNC_GRANT,         2,  0,  0, 4, 1, 0, 0);  // kind out of range
    add_row(FUNC_QUERY_ACCESS,  2,  0,  0, 3, 0, 0, 0);
    add_row(FUNC_QUERY_ACCESS,  2,  0,  0, 7, 1, 0, 0);
    add_row(FUNC_QUERY_ACCESS,  2,  0, 15, 3, 1, 0, 0);  // resource not allocated
    add_row(FUNC_SPARE_6,       0,  0,  0, 0, 1, 0, 0);
    add_row(FUNC_SPARE_7,      15, 15, 15, 7, 1, 0, 0);
    add_row(FUNC_ADD_SCOPE,     0,  0,  0, 0, 1, 1, 3);
    add_row(FUNC_QUERY_CONT,    0,  3,  0, 0, 1, 0, 0);  // new column is clear

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      offer(directed_rows[i].op, directed_rows[i].typed, directed_rows[i].want);

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == PHASE1_AT) begin
        // sender pauses until the table has answered everything
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
        tx_idle = 55;
        rx_idle <= 30;
      end
      if (n == PHASE2_AT) begin
        tx_idle = 0;
        rx_idle <= 0;
        hold_req <= 1'b1;
      end
      op = random_op();
      offer(op, 1'b0, '0);
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d transactions, %0d results checked; %0d edges merged,",
             n_sent, n_checked, n_merged);
    $display("%0d refused as cycles, %0d of %0d scopes and %0d of %0d resources allocated",
             n_cycles, n_scopes, MAX_SCOPES, n_res, MAX_RESOURCES);
    if (err_cnt == 0) begin
      $display("[scope_reachability_table] OK");
    end else begin
      $display("[scope_reachability_table] ERROR");
    end
    $finish;
  end

  // result side ready, with one long hold-off on request
  initial begin
    bit held_once;
    held_once = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !held_once) begin
        held_once = 1'b1;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      out_ready <= ($urandom_range(0, 99) >= rx_idle);
    end
  end

  // compare each result transaction with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result ok=%0b alloc_idx=%0d",
                 $time, out_data.ok, out_data.alloc_idx);
        err_cnt++;
      end else begin
        if (out_data.ok !== pending_results[0].ok) begin
          $display("%0t: ok mismatch, expected %0b actual %0b",
                   $time, pending_results[0].ok, out_data.ok);
          err_cnt++;
        end
        if (out_data.alloc_idx !== pending_results[0].alloc_idx) begin
          $display("%0t: alloc_idx mismatch, expected %0d actual %0d",
                   $time, pending_results[0].alloc_idx, out_data.alloc_idx);
          err_cnt++;
        end
        void'(pending_results.pop_front());
        n_checked++;
      end
    end
  end

  // run limit
  initial begin
    #500000;
    $display("[scope_reachability_table] ERROR");
    $finish;
  end

endmodule
